// ----- rtl/sbf_pkg.sv -----
// sbf_pkg: shared constants, types and helpers for the similar-block flattener.
// No dependencies; imported by every module under rtl.

package sbf_pkg;

   // Edge of the square block. Must be a power of two (2, 4 or 8): the average
   // is taken as the top eight bits of each channel sum.
   localparam int BlockEdge   = 8;
   localparam int Pixels      = BlockEdge * BlockEdge;
   localparam int PixelLog    = $clog2(Pixels);
   localparam int IndexWidth  = PixelLog;
   localparam int MatchWidth  = PixelLog + 1;
   localparam int SumWidth    = 8 + PixelLog;
   localparam int PixelWidth  = 32;

   localparam logic [7:0] OpaqueAlpha = 8'hff;
   localparam logic [7:0] ClearAlpha  = 8'h00;

   localparam logic [IndexWidth-1:0] LastIndex = IndexWidth'(Pixels - 1);

   typedef logic [PixelWidth-1:0] pixel_type;

   typedef enum logic [1:0] {
      STATE_LOAD = 2'b01,
      STATE_EMIT = 2'b10
   } state_type;

   // control from the sequencer to the accumulator
   typedef struct packed {
      logic accept;   // a pair transaction is taken this cycle
      logic clear;    // block fully delivered, drop counts and sums
   } accum_ctrl_type;

   // summary of the block held by the accumulator
   typedef struct packed {
      logic      flat;
      pixel_type avg_pixel;
   } accum_stat_type;

endpackage

// ----- rtl/sbf_cell.sv -----
// sbf_cell: one stage of the pixel shift line; holds a single pixel.
// Depends on sbf_pkg.

module sbf_cell (
   input  logic               clock,
   input  logic               shift,
   input  sbf_pkg::pixel_type pixel_in,
   output sbf_pkg::pixel_type pixel_out
);
   import sbf_pkg::*;

   pixel_type pixel_ff;
   pixel_type pixel_in_mux;

   assign pixel_in_mux = shift ? pixel_in : pixel_ff;

   always_ff @(posedge clock) begin
      pixel_ff <= pixel_in_mux;
   end

   assign pixel_out = pixel_ff;

endmodule

// ----- rtl/sbf_accum.sv -----
// sbf_accum: match detection, match count and channel sums of one block.
// Depends on sbf_pkg.

module sbf_accum (
   input  logic                    clock,
   input  logic                    reset,
   input  sbf_pkg::accum_ctrl_type ctrl,
   input  sbf_pkg::pixel_type      source_pixel,
   input  sbf_pkg::pixel_type      canvas_pixel,
   output sbf_pkg::accum_stat_type stat
);
   import sbf_pkg::*;

   logic [MatchWidth-1:0] match_count_ff, match_count_in;
   logic [SumWidth-1:0]   red_sum_ff, red_sum_in;
   logic [SumWidth-1:0]   green_sum_ff, green_sum_in;
   logic [SumWidth-1:0]   blue_sum_ff, blue_sum_in;
   logic                  match;

   assign match = (source_pixel[31:24] == OpaqueAlpha) && (source_pixel == canvas_pixel);

   always_comb begin
      match_count_in = match_count_ff;
      red_sum_in     = red_sum_ff;
      green_sum_in   = green_sum_ff;
      blue_sum_in    = blue_sum_ff;
      if (ctrl.clear) begin
         match_count_in = '0;
         red_sum_in     = '0;
         green_sum_in   = '0;
         blue_sum_in    = '0;
      end else if (ctrl.accept && match) begin
         match_count_in = match_count_ff + MatchWidth'(1);
         red_sum_in     = red_sum_ff   + SumWidth'(source_pixel[23:16]);
         green_sum_in   = green_sum_ff + SumWidth'(source_pixel[15:8]);
         blue_sum_in    = blue_sum_ff  + SumWidth'(source_pixel[7:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_count_ff <= '0;
         red_sum_ff     <= '0;
         green_sum_ff   <= '0;
         blue_sum_ff    <= '0;
      end else begin
         match_count_ff <= match_count_in;
         red_sum_ff     <= red_sum_in;
         green_sum_ff   <= green_sum_in;
         blue_sum_ff    <= blue_sum_in;
      end
   end

   // sum / Pixels is the top byte of each sum, count being a power of two
   assign stat.flat      = (match_count_ff == MatchWidth'(Pixels));
   assign stat.avg_pixel = {ClearAlpha, red_sum_ff[SumWidth-1 -: 8],
                            green_sum_ff[SumWidth-1 -: 8], blue_sum_ff[SumWidth-1 -: 8]};

endmodule

// ----- rtl/similar_block_flattener.sv -----
// similar_block_flattener: top level; sequencer, pixel shift line and accumulator.
// Depends on sbf_pkg, sbf_cell and sbf_accum.
//
//  channel  direction  handshake            payload
//  req_     in         req_valid/req_stall  req_source_pixel, req_canvas_pixel
//  rsp_     out        rsp_valid/rsp_stall  rsp_out_pixel, rsp_flattened, rsp_last_of_block
//
// A block takes Pixels (64) pair transactions at one a cycle while req_valid is high,
// then Pixels result transactions at one a cycle while rsp_stall is low.
// Canvas pixels travel down a row of Pixels cells; the oldest leaves first.
// req_stall is high while the block is being delivered.
// Synchronous reset clears the sequencer and accumulator; cells need none.
// rsp_stall holds the shift line and the result in place.

module similar_block_flattener (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [31:0]               req_source_pixel,
   input  logic [31:0]               req_canvas_pixel,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [31:0]               rsp_out_pixel,
   output logic                      rsp_flattened,
   output logic                      rsp_last_of_block
);
   import sbf_pkg::*;

   state_type              state_ff, state_in;
   logic [IndexWidth-1:0]  count_ff, count_in;
   logic                   req_take;
   logic                   rsp_take;
   logic                   shift;
   accum_ctrl_type         accum_ctrl;
   accum_stat_type         accum_stat;
   pixel_type              chain [Pixels+1];

   assign req_stall = (state_ff != STATE_LOAD);
   assign rsp_valid = (state_ff == STATE_EMIT);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign shift     = req_take || rsp_take;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      case (state_ff)
         STATE_LOAD: begin
            if (req_take) begin
               count_in = count_ff + IndexWidth'(1);
               if (count_ff == LastIndex) begin
                  state_in = STATE_EMIT;
                  count_in = '0;
               end
            end
         end
         STATE_EMIT: begin
            if (rsp_take) begin
               count_in = count_ff + IndexWidth'(1);
               if (count_ff == LastIndex) begin
                  state_in = STATE_LOAD;
                  count_in = '0;
               end
            end
         end
         default: begin
            state_in = STATE_LOAD;
            count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_LOAD;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   assign accum_ctrl.accept = req_take;
   assign accum_ctrl.clear  = rsp_take && (count_ff == LastIndex);

   sbf_accum u_accum (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (accum_ctrl),
      .source_pixel (req_source_pixel),
      .canvas_pixel (req_canvas_pixel),
      .stat         (accum_stat)
   );

   assign chain[0] = req_canvas_pixel;

   for (genvar i = 0; i < Pixels; i++) begin : g_cell
      sbf_cell u_cell (
         .clock     (clock),
         .shift     (shift),
         .pixel_in  (chain[i]),
         .pixel_out (chain[i+1])
      );
   end

   assign rsp_out_pixel     = accum_stat.flat ? accum_stat.avg_pixel : chain[Pixels];
   assign rsp_flattened     = accum_stat.flat;
   assign rsp_last_of_block = rsp_valid && (count_ff == LastIndex);

   a_emit_follows_load: assert property (@(posedge clock) disable iff (reset)
      req_take && (count_ff == LastIndex) |=> rsp_valid && (count_ff == '0))
      else $error("block not delivered after its last pair");

   a_load_follows_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_take && rsp_last_of_block |=> !rsp_valid && (count_ff == '0))
      else $error("delivery did not end after the last pixel");

   a_flat_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(rsp_valid) |-> $stable(rsp_flattened))
      else $error("flattened changed within a block");

   a_flat_clear_alpha: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_flattened |-> rsp_out_pixel[31:24] == ClearAlpha)
      else $error("flattened pixel is not transparent");

endmodule

// ----- dv/tb_similar_block_flattener.sv -----
// tb_similar_block_flattener: self-checking bench for similar_block_flattener.
// Depends on sbf_pkg and the RTL under rtl; carries its own block predictor.
// Random idle on both channels; each result transaction is checked as it arrives.

module tb_similar_block_flattener;
   timeunit 1ns;
   timeprecision 1ps;

   import sbf_pkg::*;

   typedef struct {
      pixel_type src;
      pixel_type canvas;
      bit        drain_first;   // sender waits for all due results before this one
   } pair_type;

   typedef struct {
      pixel_type pixel;
      bit        flat;
      bit        last;
   } block_out_type;

   typedef enum {
      BLK_WHITE,
      BLK_BLACK,
      BLK_LAST_TRANSLUCENT,
      BLK_FIRST_DIFFERS,
      BLK_CLEAR_EXTREMES,
      BLK_FLAT,
      BLK_BROKEN,
      BLK_NOISE
   } block_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_source_pixel = '0;
   logic [31:0] req_canvas_pixel = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_out_pixel;
   logic        rsp_flattened;
   logic        rsp_last_of_block;

   similar_block_flattener dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_source_pixel  (req_source_pixel),
      .req_canvas_pixel  (req_canvas_pixel),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_pixel     (rsp_out_pixel),
      .rsp_flattened     (rsp_flattened),
      .rsp_last_of_block (rsp_last_of_block)
   );

   // predictor state
   pixel_type             held_canvas [Pixels];
   logic [MatchWidth-1:0] pair_cnt = '0;
   logic [MatchWidth-1:0] match_cnt = '0;
   logic [SumWidth-1:0]   red_sum = '0;
   logic [SumWidth-1:0]   green_sum = '0;
   logic [SumWidth-1:0]   blue_sum = '0;

   pair_type      pairs_to_send [$];
   block_out_type pixels_due [$];
   pair_type      next_pair;
   block_out_type want;

   logic req_fire = 1'b0;
   int   send_gap = 0;
   int   hold_gap = 0;
   int   mismatches = 0;
   int   pairs_taken = 0;
   int   results_seen = 0;
   int   blocks_seen = 0;
   int   flat_blocks = 0;

   initial forever #6 clock = ~clock;

   // Fold one accepted pair into the block; at the block's end queue its pixels.
   task automatic absorb_pair(pixel_type src, pixel_type canvas);
      logic     flat;
      pixel_type avg;
      held_canvas[pair_cnt[IndexWidth-1:0]] = canvas;
      if (src[31:24] == OpaqueAlpha && src == canvas) begin
         match_cnt = match_cnt + MatchWidth'(1);
         red_sum   = red_sum + SumWidth'(src[23:16]);
         green_sum = green_sum + SumWidth'(src[15:8]);
         blue_sum  = blue_sum + SumWidth'(src[7:0]);
      end
      pair_cnt = pair_cnt + MatchWidth'(1);
      if (pair_cnt == MatchWidth'(Pixels)) begin
         flat = (match_cnt == MatchWidth'(Pixels));
         avg = {ClearAlpha, 8'(red_sum / Pixels), 8'(green_sum / Pixels),
                8'(blue_sum / Pixels)};
         for (int k = 0; k < Pixels; k++)
            pixels_due.push_back('{flat ? avg : held_canvas[k], flat, k == Pixels - 1});
         pair_cnt  = '0;
         match_cnt = '0;
         red_sum   = '0;
         green_sum = '0;
         blue_sum  = '0;
      end
   endtask

   task automatic add_block(block_kind_type kind, bit drain_first);
      pair_type    blk [Pixels];
      logic [31:0] rgb;
      int          spot;
      logic [7:0]  alpha;
      for (int i = 0; i < Pixels; i++) begin
         rgb = $urandom();
         case (kind)
            BLK_WHITE:
               blk[i] = '{32'hffff_ffff, 32'hffff_ffff, 1'b0};
            BLK_BLACK:
               blk[i] = '{{OpaqueAlpha, 24'h0}, {OpaqueAlpha, 24'h0}, 1'b0};
            BLK_CLEAR_EXTREMES:
               blk[i] = '{32'h0, i[0] ? 32'hffff_ffff : 32'h0, 1'b0};
            BLK_NOISE: begin
               blk[i].src = rgb;
               blk[i].canvas = ($urandom_range(0, 3) == 0) ? rgb : $urandom();
               blk[i].drain_first = 1'b0;
            end
            default:
               blk[i] = '{{OpaqueAlpha, rgb[23:0]}, {OpaqueAlpha, rgb[23:0]}, 1'b0};
         endcase
      end
      case (kind)
         BLK_LAST_TRANSLUCENT: begin
            // equal pixels, but alpha one short of opaque
            blk[Pixels-1].src[31:24] = 8'hfe;
            blk[Pixels-1].canvas[31:24] = 8'hfe;
         end
         BLK_FIRST_DIFFERS:
            blk[0] = '{32'hffff_ffff, 32'h0, 1'b0};
         BLK_BROKEN:
            repeat ($urandom_range(1, 3)) begin
               spot = $urandom_range(0, Pixels - 1);
               if ($urandom_range(0, 1) == 1) begin
                  alpha = 8'($urandom_range(0, 254));
                  blk[spot].src[31:24] = alpha;
                  blk[spot].canvas[31:24] = alpha;
               end else begin
                  blk[spot].canvas[$urandom_range(0, 31)] ^= 1'b1;
               end
            end
         default: ;
      endcase
      blk[0].drain_first = drain_first;
      foreach (blk[i]) pairs_to_send.push_back(blk[i]);
   endtask

   // driver: pair transactions and result stall, changed on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (send_gap != 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pairs_to_send.size() == 0) begin
            req_valid <= 1'b0;
         end else if (pairs_to_send[0].drain_first && pixels_due.size() != 0) begin
            req_valid <= 1'b0;
         end else begin
            next_pair = pairs_to_send.pop_front();
            req_valid <= 1'b1;
            req_source_pixel <= next_pair.src;
            req_canvas_pixel <= next_pair.canvas;
            if (pairs_to_send.size() >= 80 && $urandom_range(0, 9) == 0)
               send_gap = $urandom_range(1, 16);
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_gap != 0) begin
         hold_gap--;
         rsp_stall <= 1'b1;
      end else if (pairs_to_send.size() >= 80 && $urandom_range(0, 11) == 0) begin
         hold_gap = $urandom_range(0, 15);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: both channels sampled on the rising edge
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= (req_valid === 1'b1 && req_stall === 1'b0);
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            absorb_pair(req_source_pixel, req_canvas_pixel);
            pairs_taken++;
         end
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            results_seen++;
            if (pixels_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result transaction with nothing due: pixel %h flat %b last %b",
                           $realtime, rsp_out_pixel, rsp_flattened, rsp_last_of_block);
            end else begin
               want = pixels_due.pop_front();
               if (rsp_out_pixel !== want.pixel || rsp_flattened !== want.flat ||
                   rsp_last_of_block !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: expected pixel %h flat %b last %b, got %h %b %b",
                              $realtime, want.pixel, want.flat, want.last,
                              rsp_out_pixel, rsp_flattened, rsp_last_of_block);
               end
               if (want.last) begin
                  blocks_seen++;
                  if (want.flat) flat_blocks++;
               end
            end
         end
      end
   end

   initial begin
      block_kind_type kind;
      int             pick;
      add_block(BLK_WHITE, 1'b0);
      add_block(BLK_BLACK, 1'b0);
      add_block(BLK_LAST_TRANSLUCENT, 1'b0);
      add_block(BLK_FIRST_DIFFERS, 1'b0);
      add_block(BLK_CLEAR_EXTREMES, 1'b0);
      for (int b = 0; b < 2; b++) begin
         pick = $urandom_range(0, 7);
         kind = (pick < 4) ? BLK_FLAT : (pick < 6) ? BLK_BROKEN : BLK_NOISE;
         add_block(kind, b == 0);
      end

      repeat (12) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      do @(posedge clock); while (pairs_to_send.size() != 0 || req_valid);
      while (pixels_due.size() != 0) @(posedge clock);
      repeat (2 * Pixels + 8) @(posedge clock);

      $display("%0d pair transactions over %0d blocks; %0d blocks flattened", pairs_taken,
               blocks_seen, flat_blocks);
      $display("%0d result transactions checked, %0d mismatches", results_seen, mismatches);
      if (mismatches == 0)
         $display("similar_block_flattener: match");
      else
         $display("similar_block_flattener: mismatch");
      $finish;
   end

   initial begin
      #5ms;
      $display("similar_block_flattener: mismatch");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/sbf_pkg.sv
rtl/sbf_cell.sv
rtl/sbf_accum.sv
rtl/similar_block_flattener.sv
dv/tb_similar_block_flattener.sv
